// ----- hw/rtl/ats_pkg.sv -----
// Shared types, constants and the arctangent table for the tilt-to-screen core.
package ats_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int ACC_FRAC        = 16;
    localparam int NUM_GUARD       = 8;
    localparam int ATAN_TAB_LEN    = 24;
    localparam int ATAN_W          = 22;
    localparam int Z_W             = 25;
    localparam int HALF_W          = 10;
    localparam int COORD_W         = 11;
    localparam int ANGLE_W         = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_X_HALF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HALF = 2'd1;

    localparam logic [HALF_W-1:0] X_HALF_RST = 10'd64;
    localparam logic [HALF_W-1:0] Y_HALF_RST = 10'd32;

    // 90 degrees at the output and accumulator scales
    localparam int ANGLE_FULL = 90 << ANGLE_FRAC_BITS;
    localparam int Z_FULL     = 90 << ACC_FRAC;
    localparam int ROUND_HALF = 1 << (ACC_FRAC - ANGLE_FRAC_BITS - 1);

    typedef struct packed {
        logic vld;
        logic neg;
        logic num_zero;
        logic den_zero;
    } t_ctl;

    // atan(2^-i) in degrees, scaled by 2^16 and rounded
    function automatic logic [ATAN_W-1:0] ats_atan_deg(input int unsigned idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            0:  v = 22'd2949120;
            1:  v = 22'd1740967;
            2:  v = 22'd919879;
            3:  v = 22'd466945;
            4:  v = 22'd234379;
            5:  v = 22'd117304;
            6:  v = 22'd58666;
            7:  v = 22'd29335;
            8:  v = 22'd14668;
            9:  v = 22'd7334;
            10: v = 22'd3667;
            11: v = 22'd1833;
            12: v = 22'd917;
            13: v = 22'd458;
            14: v = 22'd229;
            15: v = 22'd115;
            16: v = 22'd57;
            17: v = 22'd29;
            18: v = 22'd14;
            19: v = 22'd7;
            20: v = 22'd4;
            21: v = 22'd2;
            22: v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/ats_sqrt_cell.sv -----
// One cell of the pipelined integer square root: settles one root bit.
module ats_sqrt_cell import ats_pkg::*; #(
    parameter int WR = 48,
    parameter int WQ = 24,
    parameter int WM = 16,
    parameter int K  = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctl          i_ctl,
    input  logic [WR-1:0] i_rem,
    input  logic [WQ-1:0] i_root,
    input  logic [WM-1:0] i_mag,
    output t_ctl          o_ctl,
    output logic [WR-1:0] o_rem,
    output logic [WQ-1:0] o_root,
    output logic [WM-1:0] o_mag
);

    localparam int WT = WR + 2;

    logic [WT-1:0] w_rem_x;
    logic [WT-1:0] w_trial;
    logic          w_take;
    t_ctl          r_ctl;
    logic [WR-1:0] r_rem;
    logic [WQ-1:0] r_root;
    logic [WM-1:0] r_mag;
    logic [WR-1:0] n_rem;
    logic [WQ-1:0] n_root;

    // trial = 2*root*2^K + 4^K
    assign w_rem_x = WT'(i_rem);
    assign w_trial = (WT'(i_root) << (K + 1)) + (WT'(1) << (2 * K));
    assign w_take  = w_rem_x >= w_trial;

    always_comb begin
        n_rem  = i_rem;
        n_root = i_root;
        if (w_take) begin
            n_rem  = WR'(w_rem_x - w_trial);
            n_root = i_root | (WQ'(1) << K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_mag  <= i_mag;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_mag  = r_mag;

endmodule

// ----- hw/rtl/ats_cordic_cell.sv -----
// One vectoring CORDIC cell: a single rotation with its fixed shift and angle.
module ats_cordic_cell import ats_pkg::*; #(
    parameter int WC    = 27,
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_ctl                 i_ctl,
    input  logic signed [WC-1:0] i_x,
    input  logic signed [WC-1:0] i_y,
    input  logic signed [Z_W-1:0] i_z,
    output t_ctl                 o_ctl,
    output logic signed [WC-1:0] o_x,
    output logic signed [WC-1:0] o_y,
    output logic signed [Z_W-1:0] o_z
);

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(ats_atan_deg(STAGE));

    logic signed [WC-1:0]  w_dx;
    logic signed [WC-1:0]  w_dy;
    logic                  w_up;
    t_ctl                  r_ctl;
    logic signed [WC-1:0]  r_x;
    logic signed [WC-1:0]  r_y;
    logic signed [Z_W-1:0] r_z;

    // shift that truncates toward zero
    function automatic logic signed [WC-1:0] f_div(input logic signed [WC-1:0] v);
        return v[WC-1] ? -((-v) >>> STAGE) : (v >>> STAGE);
    endfunction

    assign w_dx = f_div(i_y);
    assign w_dy = f_div(i_x);
    assign w_up = i_y > 0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_up) begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + ATAN;
            end else begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - ATAN;
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

// ----- hw/rtl/ats_post.sv -----
// Angle finishing (clamp, round, sign, special cases) and screen coordinate.
module ats_post import ats_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_ctl                     i_ctl,
    input  logic signed [Z_W-1:0]    i_z,
    input  logic [HALF_W-1:0]        i_half,
    output t_ctl                     o_ctl,
    output logic signed [ANGLE_W-1:0] o_ang,
    output logic [COORD_W-1:0]       o_coord
);

    localparam int LW = HALF_W + ANGLE_FRAC_BITS + 1;

    logic signed [Z_W-1:0]     w_zc;
    logic [Z_W-1:0]            w_q;
    logic [ANGLE_W-1:0]        w_mag;
    logic signed [ANGLE_W-1:0] n_ang;
    t_ctl                      r_ctl;
    logic signed [ANGLE_W-1:0] r_ang;
    logic signed [LW-1:0]      w_ang_x;
    logic signed [LW-1:0]      w_lim;
    logic [ANGLE_W-1:0]        w_abs;
    logic [COORD_W-1:0]        w_deg;

    always_comb begin
        w_zc = i_z;
        if (i_z < 0) begin
            w_zc = '0;
        end else if (i_z > Z_W'(Z_FULL)) begin
            w_zc = Z_W'(Z_FULL);
        end
        w_q = (Z_W'(w_zc) + Z_W'(ROUND_HALF)) >> (ACC_FRAC - ANGLE_FRAC_BITS);
        if (w_q > Z_W'(ANGLE_FULL)) begin
            w_q = Z_W'(ANGLE_FULL);
        end
        priority if (i_ctl.num_zero) begin
            w_mag = '0;
        end else if (i_ctl.den_zero) begin
            w_mag = ANGLE_W'(ANGLE_FULL);
        end else begin
            w_mag = ANGLE_W'(w_q);
        end
        n_ang = i_ctl.neg ? -$signed(w_mag) : $signed(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
        end
    end

    // coordinate: saturate at the half span, else truncate toward zero
    assign w_ang_x = LW'(r_ang);
    assign w_lim   = $signed(LW'(i_half) << ANGLE_FRAC_BITS);
    assign w_abs   = r_ang[ANGLE_W-1] ? ANGLE_W'(-r_ang) : ANGLE_W'(r_ang);
    assign w_deg   = COORD_W'(w_abs >> ANGLE_FRAC_BITS);

    always_comb begin
        priority if (w_ang_x >= w_lim) begin
            o_coord = {i_half, 1'b0};
        end else if (w_ang_x <= -w_lim) begin
            o_coord = '0;
        end else if (r_ang[ANGLE_W-1]) begin
            o_coord = COORD_W'(i_half) - w_deg;
        end else begin
            o_coord = COORD_W'(i_half) + w_deg;
        end
    end

    assign o_ctl = r_ctl;
    assign o_ang = r_ang;

endmodule

// ----- hw/rtl/accel_tilt_to_screen_position_core.sv -----
// Top level: squares, two square-root rows, two CORDIC rows, finishing and output register.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------------------------------
//  sample   | i_valid / o_ready            | i_accel_x, i_accel_y, i_accel_z
//  result   | o_valid / i_ready            | o_roll_angle, o_pitch_angle, o_screen_x/y
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while no held result freezes the pipeline. From acceptance
// to o_valid a request passes one squaring stage, one square-root cell per root bit,
// one CORDIC cell per rotation, one finishing stage and the output register.
// Synchronous active-low reset empties the pipeline and loads the half spans (64, 32).
// A held result freezes the whole pipeline once a finished request waits behind it;
// o_ready then drops. Until then bubbles keep advancing.
module accel_tilt_to_screen_position_core import ats_pkg::*; #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_z,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [ANGLE_W-1:0] o_roll_angle,
    output logic signed [ANGLE_W-1:0] o_pitch_angle,
    output logic [COORD_W-1:0]        o_screen_x,
    output logic [COORD_W-1:0]        o_screen_y,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [HALF_W-1:0]         i_cfg_data
);

    localparam int W    = SAMPLE_WIDTH;
    localparam int W2   = 2 * W;
    localparam int WQ   = W + NUM_GUARD;
    localparam int WR   = W2 + 2 * NUM_GUARD;
    localparam int WC   = W + NUM_GUARD + 3;
    localparam int NSTG = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;

    logic                      w_en;
    logic [HALF_W-1:0]         r_x_half;
    logic [HALF_W-1:0]         r_y_half;
    logic                      r_s1_vld;
    logic [W2-1:0]             r_sq [3];
    logic [W-1:0]              r_mag [2];
    logic                      r_neg [2];
    logic [W2-1:0]             w_sq [3];
    t_ctl                      w_post_ctl [2];
    logic signed [ANGLE_W-1:0] w_post_ang [2];
    logic [COORD_W-1:0]        w_post_coord [2];
    logic                      r_out_vld;
    logic signed [ANGLE_W-1:0] r_out_ang [2];
    logic [COORD_W-1:0]        r_out_coord [2];

    // advance unless a finished request waits behind a held output
    assign w_en        = !(w_post_ctl[0].vld && r_out_vld && !i_ready);
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_half <= X_HALF_RST;
            r_y_half <= Y_HALF_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_X_HALF: r_x_half <= i_cfg_data;
                REG_Y_HALF: r_y_half <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_sq[0] = $unsigned(W2'(i_accel_x) * W2'(i_accel_x));
    assign w_sq[1] = $unsigned(W2'(i_accel_y) * W2'(i_accel_y));
    assign w_sq[2] = $unsigned(W2'(i_accel_z) * W2'(i_accel_z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_valid;
        end
    end

    // lane 0 (roll) takes y as numerator, lane 1 (pitch) takes x
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq[0]  <= w_sq[0];
            r_sq[1]  <= w_sq[1];
            r_sq[2]  <= w_sq[2];
            r_mag[0] <= i_accel_y[W-1] ? W'(-i_accel_y) : W'(i_accel_y);
            r_mag[1] <= i_accel_x[W-1] ? W'(-i_accel_x) : W'(i_accel_x);
            r_neg[0] <= i_accel_y[W-1];
            r_neg[1] <= i_accel_x[W-1];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        t_ctl                  w_s_ctl  [WQ+1];
        logic [WR-1:0]         w_s_rem  [WQ+1];
        logic [WQ-1:0]         w_s_root [WQ+1];
        logic [W-1:0]          w_s_mag  [WQ+1];
        t_ctl                  w_c_ctl  [NSTG+1];
        logic signed [WC-1:0]  w_c_x    [NSTG+1];
        logic signed [WC-1:0]  w_c_y    [NSTG+1];
        logic signed [Z_W-1:0] w_c_z    [NSTG+1];

        assign w_s_ctl[0]  = '{vld: r_s1_vld, neg: r_neg[l],
                               num_zero: (r_mag[l] == '0), den_zero: 1'b0};
        assign w_s_rem[0]  = {((l == 0) ? r_sq[0] : r_sq[1]) + r_sq[2],
                              (2 * NUM_GUARD)'(0)};
        assign w_s_root[0] = '0;
        assign w_s_mag[0]  = r_mag[l];

        for (genvar j = 0; j < WQ; j++) begin : g_sqrt
            ats_sqrt_cell #(
                .WR (WR),
                .WQ (WQ),
                .WM (W),
                .K  (WQ - 1 - j)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ctl   (w_s_ctl[j]),
                .i_rem   (w_s_rem[j]),
                .i_root  (w_s_root[j]),
                .i_mag   (w_s_mag[j]),
                .o_ctl   (w_s_ctl[j+1]),
                .o_rem   (w_s_rem[j+1]),
                .o_root  (w_s_root[j+1]),
                .o_mag   (w_s_mag[j+1])
            );
        end

        assign w_c_ctl[0] = '{vld: w_s_ctl[WQ].vld, neg: w_s_ctl[WQ].neg,
                              num_zero: w_s_ctl[WQ].num_zero,
                              den_zero: (w_s_root[WQ] == '0)};
        assign w_c_x[0]   = $signed(WC'(w_s_root[WQ]));
        assign w_c_y[0]   = $signed(WC'(w_s_mag[WQ]) << NUM_GUARD);
        assign w_c_z[0]   = '0;

        for (genvar s = 0; s < NSTG; s++) begin : g_cordic
            ats_cordic_cell #(
                .WC    (WC),
                .STAGE (s)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ctl   (w_c_ctl[s]),
                .i_x     (w_c_x[s]),
                .i_y     (w_c_y[s]),
                .i_z     (w_c_z[s]),
                .o_ctl   (w_c_ctl[s+1]),
                .o_x     (w_c_x[s+1]),
                .o_y     (w_c_y[s+1]),
                .o_z     (w_c_z[s+1])
            );
        end

        ats_post u_post (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_c_ctl[NSTG]),
            .i_z     (w_c_z[NSTG]),
            .i_half  ((l == 0) ? r_x_half : r_y_half),
            .o_ctl   (w_post_ctl[l]),
            .o_ang   (w_post_ang[l]),
            .o_coord (w_post_coord[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en && w_post_ctl[0].vld) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_post_ctl[0].vld) begin
            r_out_ang[0]   <= w_post_ang[0];
            r_out_ang[1]   <= w_post_ang[1];
            r_out_coord[0] <= w_post_coord[0];
            r_out_coord[1] <= w_post_coord[1];
        end
    end

    assign o_valid       = r_out_vld;
    assign o_roll_angle  = r_out_ang[0];
    assign o_pitch_angle = r_out_ang[1];
    assign o_screen_x    = r_out_coord[0];
    assign o_screen_y    = r_out_coord[1];

`ifndef SYNTH
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_post_ctl[0].vld == w_post_ctl[1].vld)
        else $error("roll and pitch lanes out of step");

    a_stall_only_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> (r_out_vld && !i_ready))
        else $error("pipeline stalled without a held result");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle <= 16'sd23040 && o_roll_angle >= -16'sd23040))
        else $error("roll angle beyond 90 degrees");

    a_screen_x_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_screen_x <= {r_x_half, 1'b0}))
        else $error("screen x beyond twice the half span");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid straight after reset");
`endif

endmodule

// ----- sim/tb_accel_tilt_to_screen_position_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the accelerometer tilt to screen position core.
module tb_accel_tilt_to_screen_position_core;
    import ats_pkg::*;

    localparam int SW       = 16;
    localparam int STAGES   = 16;
    localparam int LATENCY  = SW + 11 + STAGES;
    localparam int N_RANDOM = 1800;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic [COORD_W-1:0]        sx;
        logic [COORD_W-1:0]        sy;
    } t_tilt;

    typedef struct {
        logic signed [SW-1:0] ax;
        logic signed [SW-1:0] ay;
        logic signed [SW-1:0] az;
        bit                   known;
        t_tilt                res;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [SW-1:0] i_accel_x, i_accel_y, i_accel_z;
    logic signed [ANGLE_W-1:0] o_roll_angle, o_pitch_angle;
    logic [COORD_W-1:0] o_screen_x, o_screen_y;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [HALF_W-1:0] i_cfg_data;

    accel_tilt_to_screen_position_core #(.SAMPLE_WIDTH(SW), .CORDIC_STAGES(STAGES)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .o_valid(o_valid), .i_ready(i_ready), .o_roll_angle(o_roll_angle),
        .o_pitch_angle(o_pitch_angle), .o_screen_x(o_screen_x), .o_screen_y(o_screen_y),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [HALF_W-1:0] x_half, y_half;
    t_tilt             pending_tilt[$];
    int                n_errors = 0;
    int                idle_cycles = 0;
    bit                rx_enable = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // atan2(num, sqrt(a^2 + b^2)) in Q8.8 degrees, vectoring CORDIC
    function automatic logic signed [ANGLE_W-1:0] tilt_deg(longint num, longint a, longint b);
        longint unsigned sq;
        longint den, xv, yv, z, q, dx, dy;
        sq = longint'(a * a) + longint'(b * b);
        den = longint'(int_sqrt(sq << (2 * NUM_GUARD)));
        if (num == 0) return '0;
        if (den == 0) return ANGLE_W'(num > 0 ? ANGLE_FULL : -ANGLE_FULL);
        xv = den;
        yv = (num < 0 ? -num : num) * 256;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = yv / (64'sd1 <<< i);
            dy = xv / (64'sd1 <<< i);
            if (yv > 0) begin
                xv += dx; yv -= dy; z += longint'(ats_atan_deg(i));
            end else begin
                xv -= dx; yv += dy; z -= longint'(ats_atan_deg(i));
            end
        end
        if (z < 0) z = 0;
        if (z > Z_FULL) z = Z_FULL;
        q = (z + ROUND_HALF) >>> (ACC_FRAC - ANGLE_FRAC_BITS);
        if (q > ANGLE_FULL) q = ANGLE_FULL;
        return ANGLE_W'(num < 0 ? -q : q);
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(longint ang, longint h);
        longint lim = h * 256;
        longint deg;
        if (ang >= lim) return COORD_W'(2 * h);
        if (ang <= -lim) return '0;
        deg = (ang < 0 ? -ang : ang) >>> ANGLE_FRAC_BITS;
        return COORD_W'(ang < 0 ? h - deg : h + deg);
    endfunction

    function automatic t_tilt predict_tilt(longint ax, longint ay, longint az);
        t_tilt t;
        t.roll  = tilt_deg(ay, ax, az);
        t.pitch = tilt_deg(ax, ay, az);
        t.sx    = clamp_coord(t.roll, x_half);
        t.sy    = clamp_coord(t.pitch, y_half);
        return t;
    endfunction

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (n > 0) i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_sample(logic signed [SW-1:0] ax, ay, az, bit known, t_tilt want);
        t_tilt t;
        t = known ? want : predict_tilt(ax, ay, az);
        i_valid   <= 1'b1;
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_accel_z <= az;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_tilt.push_back(t);
    endtask

    task automatic drain();
        int n = 0;
        i_valid <= 1'b0;
        while (pending_tilt.size() != 0 && n < WD_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_half(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_X_HALF) x_half = v;
        else if (idx == REG_Y_HALF) y_half = v;
    endtask

    function automatic logic signed [SW-1:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return $signed(16'($urandom_range(0, 65535)) >>> $urandom_range(0, 15));
            1: return SW'($signed(16'($urandom_range(0, 8))) - 4);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // checker: compare against the oldest expectation; random back-pressure once rx_enable is set
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tilt.size() == 0) begin
                $error("unexpected result roll=%0d pitch=%0d", o_roll_angle, o_pitch_angle);
                n_errors++;
            end else begin
                t_tilt e;
                e = pending_tilt.pop_front();
                if (o_roll_angle !== e.roll) begin
                    $error("roll_angle exp %0d got %0d", e.roll, o_roll_angle); n_errors++;
                end
                if (o_pitch_angle !== e.pitch) begin
                    $error("pitch_angle exp %0d got %0d", e.pitch, o_pitch_angle); n_errors++;
                end
                if (o_screen_x !== e.sx) begin
                    $error("screen_x exp %0d got %0d", e.sx, o_screen_x); n_errors++;
                end
                if (o_screen_y !== e.sy) begin
                    $error("screen_y exp %0d got %0d", e.sy, o_screen_y); n_errors++;
                end
            end
        end
        if (!rx_enable) i_ready <= 1'b1;
        else if ($urandom_range(0, 99) < 3) i_ready <= 1'b0;
        else if (!i_ready && $urandom_range(0, 3) != 0) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 9) < 8);
    end

    // watchdog: cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    t_row dir_rows[] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, 11'd64, 11'd32}},
        '{16'sd0, 16'sd100, 16'sd0, 1, '{16'sd23040, 16'sd0, 11'd128, 11'd32}},
        '{16'sd0, -16'sd100, 16'sd0, 1, '{-16'sd23040, 16'sd0, 11'd0, 11'd32}},
        '{16'sd32767, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd23040, 11'd64, 11'd64}},
        '{-16'sd32768, 16'sd0, 16'sd0, 1, '{16'sd0, -16'sd23040, 11'd64, 11'd0}},
        '{16'sd0, 16'sd0, 16'sd32767, 1, '{16'sd0, 16'sd0, 11'd64, 11'd32}},
        '{16'sd0, 16'sd0, -16'sd32768, 1, '{16'sd0, 16'sd0, 11'd64, 11'd32}},
        '{16'sd32767, 16'sd32767, 16'sd32767, 0, '{0, 0, 0, 0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 0, '{0, 0, 0, 0}},
        '{16'sd1, 16'sd1, 16'sd0, 0, '{0, 0, 0, 0}},
        '{-16'sd1, 16'sd1, 16'sd1, 0, '{0, 0, 0, 0}},
        '{16'sd1000, -16'sd1000, 16'sd16384, 0, '{0, 0, 0, 0}},
        '{-16'sd32768, 16'sd32767, 16'sd0, 0, '{0, 0, 0, 0}},
        '{16'sd5, 16'sd0, -16'sd3, 0, '{0, 0, 0, 0}},
        '{16'sd0, -16'sd7, 16'sd7, 0, '{0, 0, 0, 0}},
        '{16'sd12345, -16'sd23456, 16'sd4321, 0, '{0, 0, 0, 0}}
    };

    logic [HALF_W-1:0] half_set[] = '{10'd1, 10'd1023, 10'd90, 10'd45, 10'd89};

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b1; i_cfg_valid = 1'b0;
        i_accel_x = '0; i_accel_y = '0; i_accel_z = '0;
        i_cfg_index = '0; i_cfg_data = '0;
        x_half = X_HALF_RST; y_half = Y_HALF_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_sample(dir_rows[k].ax, dir_rows[k].ay, dir_rows[k].az,
                        dir_rows[k].known, dir_rows[k].res);
            random_gap();
        end
        drain();
        rx_enable = 1;

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                write_half(REG_X_HALF, p < 5 ? half_set[p - 1] : 10'($urandom_range(1, 1023)));
                write_half(REG_Y_HALF, p < 5 ? half_set[5 - p] : 10'($urandom_range(1, 1023)));
                i_cfg_valid <= 1'b0;
            end
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                send_sample(rand_axis(), rand_axis(), rand_axis(), 0, '{0, 0, 0, 0});
                if (n == 100) drain(); // let every outstanding request come back
                else if ($urandom_range(0, 3) == 0) random_gap();
            end
            drain();
        end

        if (n_errors == 0 && pending_tilt.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/ats_pkg.sv
hw/rtl/ats_sqrt_cell.sv
hw/rtl/ats_cordic_cell.sv
hw/rtl/ats_post.sv
hw/rtl/accel_tilt_to_screen_position_core.sv
sim/tb_accel_tilt_to_screen_position_core.sv
